// ===== rtl/nlms_pkg.sv =====
// ----------------------------------------------------------------------------
// nlms_pkg
// Field widths, register indexes and divider constants for the NLMS filter.
// ----------------------------------------------------------------------------
package nlms_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 32;
   localparam int STEP_W     = 16;
   localparam int TAPCNT_W   = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // quotient bits kept per tap; a larger quotient saturates the coefficient anyway
   localparam int DIV_STEPS  = 34;
   localparam int Q_W        = DIV_STEPS + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TAP_COUNT = 2'd0,
      REG_STEP_SIZE = 2'd1,
      REG_INVERT    = 2'd2
   } csr_index_type;

endpackage

// ===== rtl/nlms_adaptive_fir_filter.sv =====
// ----------------------------------------------------------------------------
// nlms_adaptive_fir_filter
// Normalized LMS adaptive FIR filter, fixed point, taps and coefficients kept
// in two synchronous memories and walked by one sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata / fields
//  req_     | in        | [15:0] reference_sample, [31:16] error_sample
//  rsp_     | out       | [15:0] filter_output
//  csr_     | in        | write only: 0 tap_count, 1 step_size, 2 invert_output
//
//  An item runs from its accept in ST_IDLE through a norm pass with one squarer
//  (NRD, NSQ, NACC for each tap), an adapt/filter pass (per tap: read, multiply,
//  check, 34-step restoring divide, update, MAC; the divide is skipped when the
//  quotient overflows) and ST_FIN, which loads the output register; the next
//  beat is accepted only once the item has returned to ST_IDLE.
//  After reset a clearing pass over all MAX_TAPS entries zeros both memories; no
//  beat is accepted meanwhile. A result waits in the output register while
//  the next beat is taken; a finished item holds until that register is free.
module nlms_adaptive_fir_filter #(
   parameter int MAX_TAPS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [2*nlms_pkg::SAMPLE_W-1:0]        req_tdata,  // reference_sample, error_sample
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [nlms_pkg::SAMPLE_W-1:0]          rsp_tdata,  // filter_output
   input  logic                                   csr_we,
   input  logic [nlms_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [nlms_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import nlms_pkg::*;

   localparam int AW     = $clog2(MAX_TAPS);
   localparam int CW     = $clog2(MAX_TAPS + 1);
   localparam int NORM_W = 32 + $clog2(MAX_TAPS);
   localparam int REM_W  = NORM_W + DIV_STEPS + 1;
   localparam int PROD_W = COEF_W + SAMPLE_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
   localparam int NUM_W  = STEP_W + 1 + 2*SAMPLE_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_NRD, ST_NSQ, ST_NACC, ST_RD, ST_MUL,
      ST_CHK, ST_DIV, ST_UPD, ST_ACC, ST_FIN
   } state_type;

   state_type state_ff;

   logic [TAPCNT_W-1:0]       tap_count_ff;
   logic [STEP_W-1:0]         step_size_ff;
   logic                      invert_ff;

   logic [SAMPLE_W-1:0]       tap_mem [MAX_TAPS];
   logic [COEF_W-1:0]         coef_mem [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] tap_rd_ff;
   logic signed [COEF_W-1:0]  coef_rd_ff;

   logic [CW-1:0]             idx_ff;
   logic [CW-1:0]             n_ff;
   logic signed [SAMPLE_W-1:0] ref_ff;
   logic signed [STEP_W+SAMPLE_W:0] gain_ff;
   logic [NORM_W-1:0]         norm_ff;
   logic signed [2*SAMPLE_W-1:0] sq_ff;
   logic signed [SAMPLE_W-1:0] x_cur_ff;
   logic signed [SAMPLE_W-1:0] x_prev_ff;
   logic signed [COEF_W-1:0]  w_ff;
   logic signed [NUM_W-1:0]   num_ff;
   logic                      neg_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [REM_W-1:0]          dsh_ff;
   logic [Q_W-1:0]            q_ff;
   logic [5:0]                cnt_ff;
   logic signed [PROD_W-1:0]  mac_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      rsp_tvalid_ff;
   logic [SAMPLE_W-1:0]       rsp_tdata_ff;

   // combinational helpers
   logic [CW-1:0]             n_in;
   logic                      mem_we;
   logic [AW-1:0]             mem_addr;
   logic signed [SAMPLE_W-1:0] x_new;
   logic signed [COEF_W+4:0]  delta;
   logic signed [COEF_W+4:0]  w_sum;
   logic signed [COEF_W-1:0]  w_new;
   logic signed [NUM_W-1:0]   num_abs;
   logic [REM_W-1:0]          mag_sh;
   logic [REM_W-1:0]          lim;
   logic signed [ACC_W:0]     acc_sgn;
   logic signed [ACC_W:0]     acc_rnd;
   logic signed [ACC_W:0]     y_full;
   logic [SAMPLE_W-1:0]       y_sat;
   logic                      last_tap;

   always_comb begin
      if (tap_count_ff == '0) begin
         n_in = CW'(1);
      end else if (32'(tap_count_ff) > MAX_TAPS) begin
         n_in = CW'(MAX_TAPS);
      end else begin
         n_in = CW'(tap_count_ff);
      end
   end

   assign mem_addr = idx_ff[AW-1:0];
   assign mem_we   = (state_ff == ST_CLEAR) || (state_ff == ST_UPD);
   assign last_tap = (idx_ff + CW'(1)) == n_ff;
   assign x_new    = (idx_ff == '0) ? ref_ff : x_prev_ff;

   // coefficient update with saturation
   always_comb begin
      delta = neg_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
      w_sum = $signed({{5{w_ff[COEF_W-1]}}, w_ff}) + delta;
      if (w_sum > $signed({5'b0, 1'b0, {(COEF_W-1){1'b1}}})) begin
         w_new = {1'b0, {(COEF_W-1){1'b1}}};
      end else if (w_sum < -$signed({5'b0, 1'b1, {(COEF_W-1){1'b0}}})) begin
         w_new = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
         w_new = w_sum[COEF_W-1:0];
      end
   end

   assign num_abs = num_ff[NUM_W-1] ? -num_ff : num_ff;
   assign mag_sh  = REM_W'(num_abs[NUM_W-2:0]) << (SAMPLE_W - 1);
   assign lim     = REM_W'(norm_ff) << DIV_STEPS;

   // output rounding: floor((acc + 2^29) / 2^30), then saturate
   always_comb begin
      acc_sgn = invert_ff ? -$signed({acc_ff[ACC_W-1], acc_ff})
                          : $signed({acc_ff[ACC_W-1], acc_ff});
      acc_rnd = acc_sgn + $signed((ACC_W+1)'(1) <<< 29);
      y_full  = acc_rnd >>> 30;
      if (y_full > $signed((ACC_W+1)'(32767))) begin
         y_sat = 16'h7fff;
      end else if (y_full < -$signed((ACC_W+1)'(32768))) begin
         y_sat = 16'h8000;
      end else begin
         y_sat = y_full[SAMPLE_W-1:0];
      end
   end

   // tap and coefficient memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tap_mem[mem_addr]  <= (state_ff == ST_CLEAR) ? '0 : x_new;
         coef_mem[mem_addr] <= (state_ff == ST_CLEAR) ? '0 : w_new;
      end
      tap_rd_ff  <= tap_mem[mem_addr];
      coef_rd_ff <= coef_mem[mem_addr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         tap_count_ff  <= TAPCNT_W'(32);
         step_size_ff  <= STEP_W'(3277);
         invert_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_TAP_COUNT: tap_count_ff <= csr_wdata[TAPCNT_W-1:0];
               REG_STEP_SIZE: step_size_ff <= csr_wdata[STEP_W-1:0];
               REG_INVERT:    invert_ff    <= csr_wdata[0];
               default:       ;
            endcase
         end
         // a finishing item reloads the output register itself
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_FIN)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (idx_ff == CW'(MAX_TAPS - 1)) begin
                  idx_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  ref_ff   <= $signed(req_tdata[SAMPLE_W-1:0]);
                  gain_ff  <= $signed({1'b0, step_size_ff})
                              * $signed(req_tdata[2*SAMPLE_W-1:SAMPLE_W]);
                  n_ff     <= n_in;
                  idx_ff   <= '0;
                  norm_ff  <= '0;
                  acc_ff   <= '0;
                  state_ff <= ST_NRD;
               end
            end
            ST_NRD: state_ff <= ST_NSQ;
            ST_NSQ: begin
               sq_ff    <= tap_rd_ff * tap_rd_ff;
               state_ff <= ST_NACC;
            end
            ST_NACC: begin
               if (last_tap) begin
                  // epsilon is one lsb of the norm
                  norm_ff  <= norm_ff + NORM_W'(unsigned'(sq_ff)) + NORM_W'(1);
                  idx_ff   <= '0;
                  state_ff <= ST_RD;
               end else begin
                  norm_ff  <= norm_ff + NORM_W'(unsigned'(sq_ff));
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= ST_NRD;
               end
            end
            ST_RD: state_ff <= ST_MUL;
            ST_MUL: begin
               x_cur_ff <= tap_rd_ff;
               w_ff     <= coef_rd_ff;
               num_ff   <= NUM_W'(gain_ff * tap_rd_ff);
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               neg_ff <= num_ff[NUM_W-1];
               rem_ff <= mag_sh;
               dsh_ff <= REM_W'(norm_ff) << (DIV_STEPS - 1);
               cnt_ff <= '0;
               if (mag_sh >= lim) begin
                  q_ff     <= Q_W'(1) << DIV_STEPS;
                  state_ff <= ST_UPD;
               end else begin
                  q_ff     <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (rem_ff >= dsh_ff) begin
                  rem_ff <= rem_ff - dsh_ff;
                  q_ff   <= {q_ff[Q_W-2:0], 1'b1};
               end else begin
                  q_ff   <= {q_ff[Q_W-2:0], 1'b0};
               end
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(DIV_STEPS - 1)) begin
                  state_ff <= ST_UPD;
               end
            end
            ST_UPD: begin
               // tap i takes the old tap i-1, sample enters at tap 0
               mac_ff    <= w_new * x_new;
               x_prev_ff <= x_cur_ff;
               state_ff  <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff <= acc_ff + ACC_W'(mac_ff);
               if (last_tap) begin
                  state_ff <= ST_FIN;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= ST_RD;
               end
            end
            ST_FIN: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff  <= y_sat;
                  rsp_tvalid_ff <= 1'b1;
                  idx_ff        <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
